// ===== sv/xrg_pkg.sv =====
// Shared types, constants and the xorshift step function for the range generator.
package xrg_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned ShiftA     = 13;
   localparam int unsigned ShiftB     = 17;
   localparam int unsigned ShiftC     = 5;

   typedef logic [DataWidth-1:0] word_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } xrg_cmd_type;

   function automatic word_type xrg_advance(input word_type x);
      word_type v;
      v = x;
      v = v ^ (v << ShiftA);
      v = v ^ (v >> ShiftB);
      v = v ^ (v << ShiftC);
      return v;
   endfunction

endpackage

// ===== sv/xrg_ctrl.sv =====
// Controller state machine that sequences the load, divide and result steps.
module xrg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output xrg_pkg::xrg_cmd_type cmd
);
   import xrg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.start  = (state_ff == ST_IDLE) && req_valid;
      cmd.step   = (state_ff == ST_DIVIDE);
      cmd.finish = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
               count_in = '0;
            end
         end
         ST_DIVIDE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CountWidth'(DataWidth - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/xrg_datapath.sv =====
// Datapath with generator state, restoring remainder unit and result register.
module xrg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  xrg_pkg::xrg_cmd_type cmd,
   input  logic                 csr_wr_en,
   input  xrg_pkg::word_type    csr_wr_data,
   input  xrg_pkg::word_type    req_lower_bound,
   input  xrg_pkg::word_type    req_upper_bound,
   output xrg_pkg::word_type    rsp_raw_value,
   output xrg_pkg::word_type    rsp_ranged_value,
   output logic                 rsp_range_error
);
   import xrg_pkg::*;

   word_type             gen_ff, gen_in;
   word_type             raw_ff, lower_ff, span_ff, div_ff, rem_ff;
   word_type             out_raw_ff, out_ranged_ff;
   logic                 out_err_ff;
   logic [DataWidth:0]   trial;
   logic [DataWidth:0]   diff;
   word_type             raw_next;

   assign raw_next = xrg_advance(gen_ff);
   assign trial    = {rem_ff, div_ff[DataWidth-1]};
   assign diff     = trial - {1'b0, span_ff};

   always_comb begin
      gen_in = gen_ff;
      if (csr_wr_en) begin
         gen_in = csr_wr_data;
      end else if (cmd.start) begin
         gen_in = raw_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= word_type'(1);
      end else begin
         gen_ff <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         raw_ff   <= raw_next;
         div_ff   <= raw_next;
         rem_ff   <= '0;
         lower_ff <= req_lower_bound;
         span_ff  <= req_upper_bound - req_lower_bound;
      end else if (cmd.step) begin
         div_ff <= div_ff << 1;
         if (!diff[DataWidth]) begin
            rem_ff <= diff[DataWidth-1:0];
         end else begin
            rem_ff <= trial[DataWidth-1:0];
         end
      end
      if (cmd.finish) begin
         out_raw_ff <= raw_ff;
         out_err_ff <= (span_ff == '0);
         if (span_ff == '0) begin
            out_ranged_ff <= '0;
         end else begin
            out_ranged_ff <= rem_ff + lower_ff + word_type'(1);
         end
      end
   end

   assign rsp_raw_value    = out_raw_ff;
   assign rsp_ranged_value = out_ranged_ff;
   assign rsp_range_error  = out_err_ff;

endmodule

// ===== sv/xorshift_range_generator.sv =====
// Top level of the xorshift generator with a ranged output.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   lower_bound, upper_bound
//   rsp      out        rsp_valid/rsp_stall   raw_value, ranged_value, range_error
//   csr      in         csr_wr_en             wr_data (seed)
//
// A request first advances the state, then runs the bit-serial remainder unit,
// then forms the ranged value into the output register.
// The remainder unit handles one request at a time; the next request is
// taken once the previous result sits in the output register.
// Reset loads the generator state with 1 and empties the output register.
// A stalled result holds the block in its final step until the output frees.
module xorshift_range_generator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  xrg_pkg::word_type   req_lower_bound,
   input  xrg_pkg::word_type   req_upper_bound,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output xrg_pkg::word_type   rsp_raw_value,
   output xrg_pkg::word_type   rsp_ranged_value,
   output logic                rsp_range_error,
   input  logic                csr_wr_en,
   input  xrg_pkg::word_type   csr_wr_data
);
   import xrg_pkg::*;

   xrg_cmd_type cmd;

   xrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   xrg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_range_error  (rsp_range_error)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request transfer did not make the block busy");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(cmd.finish))
      else $error("result appeared without a finish step");

   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_ranged_value == '0))
      else $error("range error with a nonzero ranged value");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.finish) |-> !cmd.start)
      else $error("start command while a request is in progress");

endmodule

// ===== dv/xorshift_range_generator_test.sv =====
// Self-checking testbench for the xorshift range generator with a directed table and random phases.
module xorshift_range_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import xrg_pkg::*;

   typedef enum logic [1:0] {
      ROW_SEED,
      ROW_PREDICT,
      ROW_KNOWN
   } row_kind_type;

   typedef struct packed {
      word_type raw;
      word_type ranged;
      logic     error;
   } result_type;

   typedef struct packed {
      row_kind_type kind;
      word_type     lower;
      word_type     upper;
      word_type     raw;
      word_type     ranged;
      logic         error;
   } stim_row_type;

   localparam int DirectedRows = 25;
   localparam int HoldCycles   = 400;
   localparam int Phases       = 6;

   logic     clock;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   word_type req_lower_bound = '0;
   word_type req_upper_bound = '0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   word_type rsp_raw_value;
   word_type rsp_ranged_value;
   logic     rsp_range_error;
   logic     csr_wr_en       = 1'b0;
   word_type csr_wr_data     = '0;

   result_type expected_results [$];
   word_type   model_state = 32'd1;
   int         mismatches  = 0;
   bit         hold_receiver = 1'b0;

   stim_row_type directed_rows [DirectedRows] = '{
      '{ROW_KNOWN,   32'h0000_0000, 32'h0000_0000, 32'h0004_2021, 32'h0, 1'b1},
      '{ROW_PREDICT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_000A, 32'h0000_0003, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0000, 32'h0000_0001, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0064, 32'h0000_00C8, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0, 1'b0},
      '{ROW_SEED,    32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_KNOWN,   32'h0000_0005, 32'h0000_0005, 32'h0, 32'h0, 1'b1},
      '{ROW_KNOWN,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0},
      '{ROW_KNOWN,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_KNOWN,   32'h0000_0007, 32'h0000_0003, 32'h0, 32'h8, 1'b0},
      '{ROW_SEED,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0001, 32'h0000_0002, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h1234_5678, 32'h1234_5679, 32'h0, 32'h0, 1'b0},
      '{ROW_SEED,    32'h8000_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0000, 32'h0000_0003, 32'h0, 32'h0, 1'b0},
      '{ROW_PREDICT, 32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_SEED,    32'h0000_0001, 32'h0000_0000, 32'h0, 32'h0, 1'b0},
      '{ROW_KNOWN,   32'h0000_0000, 32'h0000_0000, 32'h0004_2021, 32'h0, 1'b1},
      '{ROW_PREDICT, 32'h0000_0000, 32'h0000_0007, 32'h0, 32'h0, 1'b0}
   };

   xorshift_range_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_range_error  (rsp_range_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[xorshift_range_generator] ERROR");
      $finish;
   end

   function automatic word_type xorshift_next(input word_type s);
      word_type t;
      t = s ^ (s << ShiftA);
      t = t ^ (t >> ShiftB);
      return t ^ (t << ShiftC);
   endfunction

   function automatic result_type predict_result(input word_type lo, input word_type hi,
                                                 input word_type raw);
      word_type   span;
      result_type r;
      span     = hi - lo;
      r.raw    = raw;
      r.error  = (span == 32'd0);
      r.ranged = r.error ? 32'd0 : (raw % span) + lo + 32'd1;
      return r;
   endfunction

   task automatic offer_request(input word_type lo, input word_type hi, input logic known,
                                input result_type known_result);
      result_type r;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_lower_bound <= lo;
      req_upper_bound <= hi;
      do @(posedge clock); while (req_stall);
      model_state = xorshift_next(model_state);
      r = known ? known_result : predict_result(lo, hi, model_state);
      expected_results.push_back(r);
   endtask

   task automatic sender_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      sender_gap(1);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_seed(input word_type value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      model_state = value;
   endtask

   // Receiver: stall pattern is redrawn at random from four modes; one long hold-off on request.
   initial begin
      int mode;
      int tick;
      mode = 0;
      tick = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles - 1) @(negedge clock);
         end else begin
            if (tick % 50 == 0) begin
               mode = $urandom_range(0, 3);
            end
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= tick[1];
               end
            endcase
            tick++;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: raw_value %h", rsp_raw_value);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_raw_value !== want.raw) begin
               $error("raw_value: expected %h, got %h", want.raw, rsp_raw_value);
               mismatches++;
            end
            if (rsp_ranged_value !== want.ranged) begin
               $error("ranged_value: expected %h, got %h", want.ranged, rsp_ranged_value);
               mismatches++;
            end
            if (rsp_range_error !== want.error) begin
               $error("range_error: expected %b, got %b", want.error, rsp_range_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      result_type   known_r;
      word_type     lo;
      word_type     hi;
      word_type     seed_value;
      int           count;
      int           burst_left;
      int           gap;

      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedRows; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_SEED) begin
            write_seed(row.lower);
         end else begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
               sender_gap(gap);
            end
            known_r = '{raw: row.raw, ranged: row.ranged, error: row.error};
            offer_request(row.lower, row.upper, row.kind == ROW_KNOWN, known_r);
         end
      end

      for (int phase = 0; phase < Phases; phase++) begin
         case (phase)
            1: seed_value = 32'hFFFF_FFFF;
            3: seed_value = 32'h0000_0000;
            default: seed_value = $urandom;
         endcase
         write_seed(seed_value);
         count = (seed_value == 32'd0) ? 40 : 350;
         for (int n = 0; n < count; n++) begin
            if (phase == 2 && n == 0) begin
               hold_receiver = 1'b1;
            end
            if (phase == 4 && n == count / 2) begin
               drain_results();
            end
            case ($urandom_range(0, 9))
               0: begin
                  lo = $urandom;
                  hi = lo;
               end
               1, 2: begin
                  lo = $urandom;
                  hi = lo + $urandom_range(1, 64);
               end
               3: begin
                  lo = $urandom;
                  hi = lo - $urandom_range(1, 64);
               end
               4: begin
                  lo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                  hi = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
               end
               default: begin
                  lo = $urandom;
                  hi = $urandom;
               end
            endcase
            gap = 0;
            if (!(phase == 1 || (phase == 2 && n < 40))) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap        = $urandom_range(1, 10);
               end
               burst_left--;
            end
            if (gap > 0) begin
               sender_gap(gap);
            end
            offer_request(lo, hi, 1'b0, '0);
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("[xorshift_range_generator] OK");
      end else begin
         $display("[xorshift_range_generator] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/xrg_pkg.sv
sv/xrg_ctrl.sv
sv/xrg_datapath.sv
sv/xorshift_range_generator.sv
dv/xorshift_range_generator_test.sv
